// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the top level, which checks its own logic with them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ctess_pkg.sv =====
// Types, constants and helper functions shared by the cylinder tessellator.
package ctess_pkg;

    // Segment count limit and field widths.
    localparam int MaxSegments = 1024;
    localparam int SegW        = 10;
    localparam int CountW      = 11;
    localparam int SlotW       = 14;
    localparam int DivSteps    = 32;
    localparam int CordicSteps = 30;

    // CORDIC start value: the gain-compensated unit length in Q30.
    localparam logic signed [33:0] CordicGain = 34'sd652032874;

    // Rotation angles in turns, scaled by 2^32.
    localparam logic [29:0] AtanTurns [0:29] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
        30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
        30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
    };

    // Result kinds.
    localparam logic [1:0] KindStrokeVtx = 2'd0;
    localparam logic [1:0] KindFillVtx   = 2'd1;
    localparam logic [1:0] KindStrokeIdx = 2'd2;
    localparam logic [1:0] KindFillIdx   = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [2:0] RegSegments   = 3'd0;
    localparam logic [2:0] RegRadius     = 3'd1;
    localparam logic [2:0] RegHeight     = 3'd2;
    localparam logic [2:0] RegCenterX    = 3'd3;
    localparam logic [2:0] RegCenterY    = 3'd4;
    localparam logic [2:0] RegCenterZ    = 3'd5;
    localparam logic [2:0] RegDrawMode   = 3'd6;
    localparam logic [2:0] RegVertexBase = 3'd7;

    // Tag that travels with every request down the pipeline.
    typedef struct packed {
        logic [SegW-1:0] seg;
        logic            bad;
    } tag_t;

    // Payload of one divider cell.
    typedef struct packed {
        logic [CountW-1:0] rem;
        logic [31:0]       quo;
        tag_t              tag;
    } div_t;

    // Payload of one CORDIC cell.
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [31:0] z;
        logic [1:0]         quad;
        tag_t               tag;
    } cordic_t;

    // Rim point handed to the result sequencer.
    typedef struct packed {
        tag_t               tag;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } rim_t;

    // Configuration seen by the result sequencer.
    typedef struct packed {
        logic [CountW-1:0]  n;
        logic [31:0]        height;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [1:0]         draw_mode;
        logic [31:0]        vertex_base;
    } cfg_t;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -40'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

// ===== hw/rtl/cylinder_mesh_tessellator.sv =====
// Results: one result a cycle while the receiver keeps out_ready high.
// Each segment gives up to 24 results (one for an error), and the single result
// port limits the segment rate; the divider and CORDIC cell chain accepts a new
// request each cycle and stalls as a whole when the sequencer is full.
// Reset: rst_n clears all valid flags and loads the configuration reset values.
// Top level of the cylinder tessellator: configuration port, cell chains and sequencer.
`include "assert_macros.svh"

module cylinder_mesh_tessellator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ctess_pkg::SegW-1:0]    segment,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    kind,
    output logic [ctess_pkg::SlotW-1:0]   slot,
    output logic [31:0]                   index_value,
    output logic signed [31:0]            pos_x,
    output logic signed [31:0]            pos_y,
    output logic signed [31:0]            pos_z,
    output logic                          bad_segment,
    output logic                          last
);

    localparam int DN = ctess_pkg::DivSteps;
    localparam int CN = ctess_pkg::CordicSteps;

    // Configuration registers.
    logic [ctess_pkg::CountW-1:0] segments_reg;
    logic [31:0]                  radius_reg;
    logic [31:0]                  height_reg;
    logic signed [31:0]           center_x_reg;
    logic signed [31:0]           center_y_reg;
    logic signed [31:0]           center_z_reg;
    logic [1:0]                   draw_mode_reg;
    logic [31:0]                  vertex_base_reg;

    logic                         cfg_wr;
    logic [2:0]                   reg_idx;
    logic [ctess_pkg::CountW-1:0] n_eff;
    logic                         adv;
    logic                         em_take;
    ctess_pkg::cfg_t              em_cfg;

    // Pipeline signals.
    logic                         in_v_reg;
    ctess_pkg::tag_t              in_tag_reg;
    logic                         div_v [0:DN];
    ctess_pkg::div_t              div_d [0:DN];
    logic                         cor_v [0:CN];
    ctess_pkg::cordic_t           cor_d [0:CN];
    logic                         quad_v_reg;
    ctess_pkg::tag_t              quad_tag_reg;
    logic signed [33:0]           c_reg, s_reg;
    logic                         mul_v_reg;
    ctess_pkg::tag_t              mul_tag_reg;
    logic signed [66:0]           mx_reg, my_reg;
    logic                         crd_v_reg;
    ctess_pkg::rim_t              crd_reg;
    logic signed [66:0]           rx, ry;
    logic signed [33:0]           c_next, s_next;

    // Register write decode.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segments_reg    <= ctess_pkg::CountW'(60);
            radius_reg      <= 32'd65536;
            height_reg      <= 32'd65536;
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            center_z_reg    <= '0;
            draw_mode_reg   <= 2'd1;
            vertex_base_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                ctess_pkg::RegSegments:   segments_reg    <= pwdata[ctess_pkg::CountW-1:0];
                ctess_pkg::RegRadius:     radius_reg      <= pwdata;
                ctess_pkg::RegHeight:     height_reg      <= pwdata;
                ctess_pkg::RegCenterX:    center_x_reg    <= pwdata;
                ctess_pkg::RegCenterY:    center_y_reg    <= pwdata;
                ctess_pkg::RegCenterZ:    center_z_reg    <= pwdata;
                ctess_pkg::RegDrawMode:   draw_mode_reg   <= pwdata[1:0];
                ctess_pkg::RegVertexBase: vertex_base_reg <= pwdata;
                default:                  ;
            endcase
        end
    end

    // Register read mux.
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            ctess_pkg::RegSegments:   prdata = 32'(segments_reg);
            ctess_pkg::RegRadius:     prdata = radius_reg;
            ctess_pkg::RegHeight:     prdata = height_reg;
            ctess_pkg::RegCenterX:    prdata = center_x_reg;
            ctess_pkg::RegCenterY:    prdata = center_y_reg;
            ctess_pkg::RegCenterZ:    prdata = center_z_reg;
            ctess_pkg::RegDrawMode:   prdata = 32'(draw_mode_reg);
            ctess_pkg::RegVertexBase: prdata = vertex_base_reg;
            default:                  prdata = '0;
        endcase
    end

    // Effective segment count, clamped to the supported maximum.
    assign n_eff = (32'(segments_reg) > 32'(ctess_pkg::MaxSegments))
                   ? ctess_pkg::CountW'(ctess_pkg::MaxSegments) : segments_reg;

    // The whole chain moves together unless the tail holds a segment the sequencer cannot take.
    assign adv      = !crd_v_reg || em_take;
    assign in_ready = adv;

    // Input stage: range check of the requested segment.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (adv)
            in_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_tag_reg.seg <= segment;
            in_tag_reg.bad <= ({1'b0, segment} >= n_eff);
        end
    end

    // Divider chain: one quotient bit of the phase per cell.
    assign div_v[0]     = in_v_reg;
    assign div_d[0].rem = ctess_pkg::CountW'(in_tag_reg.seg);
    assign div_d[0].quo = '0;
    assign div_d[0].tag = in_tag_reg;

    for (genvar g = 0; g < DN; g++)
    begin : g_div
        ctess_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .n       (n_eff),
            .i_valid (div_v[g]),
            .i_data  (div_d[g]),
            .o_valid (div_v[g+1]),
            .o_data  (div_d[g+1])
        );
    end

    // CORDIC chain: one rotation per cell within the quadrant.
    assign cor_v[0]      = div_v[DN];
    assign cor_d[0].x    = ctess_pkg::CordicGain;
    assign cor_d[0].y    = '0;
    assign cor_d[0].z    = $signed({2'b00, div_d[DN].quo[29:0]});
    assign cor_d[0].quad = div_d[DN].quo[31:30];
    assign cor_d[0].tag  = div_d[DN].tag;

    for (genvar g = 0; g < CN; g++)
    begin : g_cordic
        ctess_cordic_cell #(.K(g)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .i_valid (cor_v[g]),
            .i_data  (cor_d[g]),
            .o_valid (cor_v[g+1]),
            .o_data  (cor_d[g+1])
        );
    end

    // Quadrant fold-out of cosine and sine.
    always_comb
    begin
        case (cor_d[CN].quad)
            2'd0:    begin c_next = cor_d[CN].x;  s_next = cor_d[CN].y;  end
            2'd1:    begin c_next = -cor_d[CN].y; s_next = cor_d[CN].x;  end
            2'd2:    begin c_next = -cor_d[CN].x; s_next = -cor_d[CN].y; end
            default: begin c_next = cor_d[CN].y;  s_next = -cor_d[CN].x; end
        endcase
    end

    // Valid flags of the three back-end stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_v_reg <= 1'b0;
            mul_v_reg  <= 1'b0;
            crd_v_reg  <= 1'b0;
        end
        else if (adv)
        begin
            quad_v_reg <= cor_v[CN];
            mul_v_reg  <= quad_v_reg;
            crd_v_reg  <= mul_v_reg;
        end
    end

    // Radius scaling, then rounding, centre offset and saturation.
    always_comb
    begin
        rx = mx_reg + (67'sd1 <<< 29);
        ry = my_reg + (67'sd1 <<< 29);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quad_tag_reg <= cor_d[CN].tag;
            c_reg        <= c_next;
            s_reg        <= s_next;
            mul_tag_reg  <= quad_tag_reg;
            mx_reg       <= 67'($signed({1'b0, radius_reg}) * c_reg);
            my_reg       <= 67'($signed({1'b0, radius_reg}) * s_reg);
            crd_reg.tag  <= mul_tag_reg;
            crd_reg.x    <= ctess_pkg::sat32(40'(rx >>> 30) + 40'(center_x_reg));
            crd_reg.y    <= ctess_pkg::sat32(40'(ry >>> 30) + 40'(center_y_reg));
        end
    end

    // Result sequencer.
    always_comb
    begin
        em_cfg.n           = n_eff;
        em_cfg.height      = height_reg;
        em_cfg.center_x    = center_x_reg;
        em_cfg.center_y    = center_y_reg;
        em_cfg.center_z    = center_z_reg;
        em_cfg.draw_mode   = draw_mode_reg;
        em_cfg.vertex_base = vertex_base_reg;
    end

    ctess_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (em_cfg),
        .in_valid    (crd_v_reg),
        .in_data     (crd_reg),
        .take        (em_take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .slot        (slot),
        .index_value (index_value),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .bad_segment (bad_segment),
        .last        (last)
    );

    // An error result stands alone.
    `CT_ASSERT_IMP(a_bad_is_last, out_valid && bad_segment, last, "error result without last")

    // Index results carry no position.
    `CT_ASSERT_IMP(a_index_no_pos,
        out_valid && (kind == ctess_pkg::KindStrokeIdx || kind == ctess_pkg::KindFillIdx),
        pos_x == 0 && pos_y == 0 && pos_z == 0, "index result with a position")

    // Results of one segment follow without a gap.
    `CT_ASSERT_NXT(a_no_gap, out_valid && out_ready && !last, out_valid,
        "gap inside the results of a segment")

endmodule

// ===== hw/rtl/ctess_div_cell.sv =====
// One restoring-division cell: produces one quotient bit of segment * 2^32 / n.
module ctess_div_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic [ctess_pkg::CountW-1:0]  n,
    input  logic                          i_valid,
    input  ctess_pkg::div_t               i_data,
    output logic                          o_valid,
    output ctess_pkg::div_t               o_data
);

    logic                         valid_reg;
    ctess_pkg::div_t              data_reg;
    ctess_pkg::div_t              data_next;
    logic [ctess_pkg::CountW:0]   rem2;
    logic                         ge;

    // Double the remainder and subtract the divisor where it fits.
    always_comb
    begin
        rem2          = {i_data.rem, 1'b0};
        ge            = (rem2 >= {1'b0, n});
        data_next     = i_data;
        data_next.rem = ge ? ctess_pkg::CountW'(rem2 - {1'b0, n})
                           : rem2[ctess_pkg::CountW-1:0];
        data_next.quo = {i_data.quo[30:0], ge};
    end

    // Valid flag of the cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= i_valid;
    end

    // Payload of the cell.
    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign o_valid = valid_reg;
    assign o_data  = data_reg;

endmodule

// ===== hw/rtl/ctess_cordic_cell.sv =====
// One CORDIC rotation cell with a fixed step number.
module ctess_cordic_cell #(
    parameter int K = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               i_valid,
    input  ctess_pkg::cordic_t i_data,
    output logic               o_valid,
    output ctess_pkg::cordic_t o_data
);

    logic               valid_reg;
    ctess_pkg::cordic_t data_reg;
    ctess_pkg::cordic_t data_next;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [31:0] ang;

    // Rotate towards zero residual angle; shifts round towards minus infinity.
    always_comb
    begin
        dx        = i_data.y >>> K;
        dy        = i_data.x >>> K;
        ang       = $signed({2'b00, ctess_pkg::AtanTurns[K]});
        data_next = i_data;
        if (!i_data.z[31])
        begin
            data_next.x = i_data.x - dx;
            data_next.y = i_data.y + dy;
            data_next.z = i_data.z - ang;
        end
        else
        begin
            data_next.x = i_data.x + dx;
            data_next.y = i_data.y - dy;
            data_next.z = i_data.z + ang;
        end
    end

    // Valid flag of the cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= i_valid;
    end

    // Payload of the cell.
    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign o_valid = valid_reg;
    assign o_data  = data_reg;

endmodule

// ===== hw/rtl/ctess_emitter.sv =====
// Result sequencer: walks the vertex and index list of one segment, one result a cycle while out_ready is high.
module ctess_emitter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ctess_pkg::cfg_t              cfg,
    input  logic                         in_valid,
    input  ctess_pkg::rim_t              in_data,
    output logic                         take,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   kind,
    output logic [ctess_pkg::SlotW-1:0]  slot,
    output logic [31:0]                  index_value,
    output logic signed [31:0]           pos_x,
    output logic signed [31:0]           pos_y,
    output logic signed [31:0]           pos_z,
    output logic                         bad_segment,
    output logic                         last
);

    localparam int SW = ctess_pkg::SlotW;

    // Positions in the result list of a segment.
    localparam logic [4:0] PFillBot   = 5'd0;
    localparam logic [4:0] PFillTop   = 5'd1;
    localparam logic [4:0] PCapBot    = 5'd2;
    localparam logic [4:0] PCapTop    = 5'd3;
    localparam logic [4:0] PTriB0     = 5'd4;
    localparam logic [4:0] PTriB1     = 5'd5;
    localparam logic [4:0] PTriB2     = 5'd6;
    localparam logic [4:0] PTriT0     = 5'd7;
    localparam logic [4:0] PTriT1     = 5'd8;
    localparam logic [4:0] PTriT2     = 5'd9;
    localparam logic [4:0] PTriS0     = 5'd10;
    localparam logic [4:0] PTriS1     = 5'd11;
    localparam logic [4:0] PTriS2     = 5'd12;
    localparam logic [4:0] PTriS3     = 5'd13;
    localparam logic [4:0] PTriS4     = 5'd14;
    localparam logic [4:0] PTriS5     = 5'd15;
    localparam logic [4:0] PStrokeBot = 5'd16;
    localparam logic [4:0] PStrokeTop = 5'd17;
    localparam logic [4:0] PLineB0    = 5'd18;
    localparam logic [4:0] PLineB1    = 5'd19;
    localparam logic [4:0] PLineT0    = 5'd20;
    localparam logic [4:0] PLineT1    = 5'd21;
    localparam logic [4:0] PLineV0    = 5'd22;
    localparam logic [4:0] PLineV1    = 5'd23;

    // Sequencer state.
    logic        busy_reg;
    logic [4:0]  pos_reg;
    logic        err_reg;
    logic        i0_reg;
    logic        stroke_reg;

    // Segment data held while its results go out.
    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic [SW-1:0] fs_reg, fsn1_reg, fsn2i_reg, fsi1_reg;
    logic [SW-1:0] s3i_reg, s3n_reg, s6n_reg, s2i_reg, s2n_reg, s4n_reg, i_reg, ni_reg;
    logic [31:0] fb_reg, fb1i_reg, fb1j_reg, fbn1_reg, fbn2i_reg, fbn2j_reg;
    logic [31:0] vbi_reg, vbj_reg, vbni_reg, vbnj_reg;

    // Output register.
    logic                       out_valid_reg;
    logic [1:0]                 kind_reg;
    logic [SW-1:0]              slot_reg;
    logic [31:0]                index_reg;
    logic signed [31:0]         px_reg, py_reg, pz_reg;
    logic                       bad_reg;
    logic                       last_reg;

    logic                       fire;
    logic                       has_next;
    logic [4:0]                 pos_next;
    logic                       final_res;
    logic                       fill_on;
    logic                       stroke_on;
    logic [ctess_pkg::CountW-1:0] j_cnt;
    logic [SW-1:0]              i14, n14, j14, fs14;
    logic [31:0]                i32, j32, n32, fb32;
    logic signed [39:0]         cz40, h40;
    logic signed [31:0]         zb, zt;
    logic [1:0]                 r_kind;
    logic [SW-1:0]              r_slot;
    logic [31:0]                r_index;
    logic signed [31:0]         r_x, r_y, r_z;

    assign fill_on   = cfg.draw_mode[0];
    assign stroke_on = cfg.draw_mode[1];

    // Bottom and top z of the cylinder.
    always_comb
    begin
        cz40 = 40'(cfg.center_z);
        h40  = $signed({9'b0, cfg.height[31:1]});
        zb   = ctess_pkg::sat32(cz40 - h40);
        zt   = ctess_pkg::sat32(cz40 + h40);
    end

    // Next position in the list, skipping the cap centres and a disabled stroke part.
    always_comb
    begin
        has_next = 1'b1;
        pos_next = pos_reg + 5'd1;
        if (pos_reg == PFillTop && !i0_reg)
            pos_next = PTriB0;
        else if (pos_reg == PTriS5 && !stroke_reg)
            has_next = 1'b0;
        else if (pos_reg == PLineV1)
            has_next = 1'b0;
    end

    assign fire      = busy_reg && (!out_valid_reg || out_ready);
    assign final_res = err_reg || !has_next;
    assign take      = in_valid && (!busy_reg || (fire && final_res));

    // Per-segment operands, derived when a segment is loaded.
    always_comb
    begin
        j_cnt = (ctess_pkg::CountW'(in_data.tag.seg) + 1'b1 == cfg.n)
                ? '0 : ctess_pkg::CountW'(in_data.tag.seg) + 1'b1;
        i14   = SW'(in_data.tag.seg);
        n14   = SW'(cfg.n);
        j14   = SW'(j_cnt);
        fs14  = stroke_on ? SW'({cfg.n, 1'b0}) : '0;
        i32   = 32'(in_data.tag.seg);
        j32   = 32'(j_cnt);
        n32   = 32'(cfg.n);
        fb32  = cfg.vertex_base + (stroke_on ? 32'({cfg.n, 1'b0}) : 32'd0);
    end

    // Sequencer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= PFillBot;
        end
        else if (take)
        begin
            busy_reg <= in_data.tag.bad || fill_on || stroke_on;
            pos_reg  <= fill_on ? PFillBot : PStrokeBot;
        end
        else if (fire && final_res)
            busy_reg <= 1'b0;
        else if (fire)
            pos_reg <= pos_next;
    end

    // Segment data load.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            err_reg    <= in_data.tag.bad;
            i0_reg     <= (in_data.tag.seg == '0);
            stroke_reg <= stroke_on;
            x_reg      <= in_data.x;
            y_reg      <= in_data.y;
            fs_reg     <= fs14;
            fsi1_reg   <= fs14 + i14 + SW'(1);
            fsn1_reg   <= fs14 + n14 + SW'(1);
            fsn2i_reg  <= fs14 + n14 + i14 + SW'(2);
            i_reg      <= i14;
            ni_reg     <= n14 + i14;
            s3i_reg    <= {i14[SW-2:0], 1'b0} + i14;
            s3n_reg    <= {n14[SW-2:0], 1'b0} + n14;
            s6n_reg    <= {n14[SW-3:0], 2'b0} + {n14[SW-2:0], 1'b0};
            s2i_reg    <= {i14[SW-2:0], 1'b0};
            s2n_reg    <= {n14[SW-2:0], 1'b0};
            s4n_reg    <= {n14[SW-3:0], 2'b0};
            fb_reg     <= fb32;
            fb1i_reg   <= fb32 + i32 + 32'd1;
            fb1j_reg   <= fb32 + j32 + 32'd1;
            fbn1_reg   <= fb32 + n32 + 32'd1;
            fbn2i_reg  <= fb32 + n32 + i32 + 32'd2;
            fbn2j_reg  <= fb32 + n32 + j32 + 32'd2;
            vbi_reg    <= cfg.vertex_base + i32;
            vbj_reg    <= cfg.vertex_base + j32;
            vbni_reg   <= cfg.vertex_base + n32 + i32;
            vbnj_reg   <= cfg.vertex_base + n32 + j32;
        end
    end

    // Fields of the result at the current list position.
    always_comb
    begin
        r_kind  = ctess_pkg::KindFillIdx;
        r_slot  = '0;
        r_index = '0;
        r_x     = '0;
        r_y     = '0;
        r_z     = '0;
        unique case (pos_reg)
            PFillBot:   begin r_kind = ctess_pkg::KindFillVtx; r_slot = fsi1_reg;
                              r_x = x_reg; r_y = y_reg; r_z = zb; end
            PFillTop:   begin r_kind = ctess_pkg::KindFillVtx; r_slot = fsn2i_reg;
                              r_x = x_reg; r_y = y_reg; r_z = zt; end
            PCapBot:    begin r_kind = ctess_pkg::KindFillVtx; r_slot = fs_reg;
                              r_x = cfg.center_x; r_y = cfg.center_y; r_z = zb; end
            PCapTop:    begin r_kind = ctess_pkg::KindFillVtx; r_slot = fsn1_reg;
                              r_x = cfg.center_x; r_y = cfg.center_y; r_z = zt; end
            PTriB0:     begin r_slot = s3i_reg;                     r_index = fb_reg;    end
            PTriB1:     begin r_slot = s3i_reg + SW'(1);            r_index = fb1j_reg;  end
            PTriB2:     begin r_slot = s3i_reg + SW'(2);            r_index = fb1i_reg;  end
            PTriT0:     begin r_slot = s3n_reg + s3i_reg;           r_index = fbn1_reg;  end
            PTriT1:     begin r_slot = s3n_reg + s3i_reg + SW'(1);  r_index = fbn2i_reg; end
            PTriT2:     begin r_slot = s3n_reg + s3i_reg + SW'(2);  r_index = fbn2j_reg; end
            PTriS0:     begin r_slot = s6n_reg + {s3i_reg[SW-2:0], 1'b0};
                              r_index = fb1i_reg; end
            PTriS1:     begin r_slot = s6n_reg + {s3i_reg[SW-2:0], 1'b0} + SW'(1);
                              r_index = fb1j_reg; end
            PTriS2:     begin r_slot = s6n_reg + {s3i_reg[SW-2:0], 1'b0} + SW'(2);
                              r_index = fbn2j_reg; end
            PTriS3:     begin r_slot = s6n_reg + {s3i_reg[SW-2:0], 1'b0} + SW'(3);
                              r_index = fb1i_reg; end
            PTriS4:     begin r_slot = s6n_reg + {s3i_reg[SW-2:0], 1'b0} + SW'(4);
                              r_index = fbn2j_reg; end
            PTriS5:     begin r_slot = s6n_reg + {s3i_reg[SW-2:0], 1'b0} + SW'(5);
                              r_index = fbn2i_reg; end
            PStrokeBot: begin r_kind = ctess_pkg::KindStrokeVtx; r_slot = i_reg;
                              r_x = x_reg; r_y = y_reg; r_z = zb; end
            PStrokeTop: begin r_kind = ctess_pkg::KindStrokeVtx; r_slot = ni_reg;
                              r_x = x_reg; r_y = y_reg; r_z = zt; end
            PLineB0:    begin r_kind = ctess_pkg::KindStrokeIdx; r_slot = s2i_reg;
                              r_index = vbi_reg; end
            PLineB1:    begin r_kind = ctess_pkg::KindStrokeIdx; r_slot = s2i_reg + SW'(1);
                              r_index = vbj_reg; end
            PLineT0:    begin r_kind = ctess_pkg::KindStrokeIdx; r_slot = s2n_reg + s2i_reg;
                              r_index = vbni_reg; end
            PLineT1:    begin r_kind = ctess_pkg::KindStrokeIdx;
                              r_slot = s2n_reg + s2i_reg + SW'(1); r_index = vbnj_reg; end
            PLineV0:    begin r_kind = ctess_pkg::KindStrokeIdx; r_slot = s4n_reg + s2i_reg;
                              r_index = vbi_reg; end
            PLineV1:    begin r_kind = ctess_pkg::KindStrokeIdx;
                              r_slot = s4n_reg + s2i_reg + SW'(1); r_index = vbni_reg; end
            default:    begin r_kind = ctess_pkg::KindFillIdx; end
        endcase
        if (err_reg)
        begin
            r_kind  = ctess_pkg::KindStrokeVtx;
            r_slot  = '0;
            r_index = '0;
            r_x     = '0;
            r_y     = '0;
            r_z     = '0;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            kind_reg  <= r_kind;
            slot_reg  <= r_slot;
            index_reg <= r_index;
            px_reg    <= r_x;
            py_reg    <= r_y;
            pz_reg    <= r_z;
            bad_reg   <= err_reg;
            last_reg  <= final_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign slot        = slot_reg;
    assign index_value = index_reg;
    assign pos_x       = px_reg;
    assign pos_y       = py_reg;
    assign pos_z       = pz_reg;
    assign bad_segment = bad_reg;
    assign last        = last_reg;

endmodule

// ===== tb/sv/tb_cylinder_mesh_tessellator.sv =====
// Self-checking testbench for the cylinder mesh tessellator.
module tb_cylinder_mesh_tessellator;

    localparam int DrainCycles = 120;
    localparam int CycleLimit  = 900000;

    // One expected or observed result.
    typedef struct {
        logic [1:0]         kind;
        logic [13:0]        slot;
        logic [31:0]        index_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               bad_segment;
        logic               last;
    } mesh_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [4:0]                    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_ready;
    logic [ctess_pkg::SegW-1:0]    segment;
    logic                          out_valid;
    logic                          out_ready;
    logic [1:0]                    kind;
    logic [ctess_pkg::SlotW-1:0]   slot;
    logic [31:0]                   index_value;
    logic signed [31:0]            pos_x;
    logic signed [31:0]            pos_y;
    logic signed [31:0]            pos_z;
    logic                          bad_segment;
    logic                          last;

    // Shadow copy of the configuration registers.
    logic [10:0]         seg_count;
    logic [31:0]         rad;
    logic [31:0]         hgt;
    logic [31:0]         cen_x;
    logic [31:0]         cen_y;
    logic [31:0]         cen_z;
    logic [1:0]          mode;
    logic [31:0]         vbase;

    mesh_result_t        pending_results[$];
    int                  fail_count;
    int                  cycle_count;
    int                  stall_left;
    bit                  steady_flow;

    cylinder_mesh_tessellator dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .segment(segment),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .slot(slot), .index_value(index_value),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .bad_segment(bad_segment), .last(last)
    );

    // Clock generation.
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Gap length: mostly short, now and then long.
    function automatic int pick_gap();
        if (steady_flow)
            return 0;
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(15, 40);
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Rim coordinate: radius times the trig value in Q30, rounded, plus the centre.
    function automatic longint rim_position(input longint trig, input logic [31:0] cen);
        longint p;
        p = longint'({32'd0, rad}) * trig + (64'sd1 <<< 29);
        return clamp32((p >>> 30) + longint'(signed'(cen)));
    endfunction

    function automatic void add_result(input logic [1:0] k, input logic [31:0] s,
                                       input logic [31:0] idx, input longint x,
                                       input longint y, input longint z);
        mesh_result_t r;
        r.kind        = k;
        r.slot        = s[13:0];
        r.index_value = idx;
        r.pos_x       = x[31:0];
        r.pos_y       = y[31:0];
        r.pos_z       = z[31:0];
        r.bad_segment = 1'b0;
        r.last        = 1'b0;
        pending_results.push_back(r);
    endfunction

    // Works out every result that one segment request produces.
    function automatic void tessellate_segment(input logic [9:0] seg);
        logic [31:0]   n;
        logic [31:0]   i;
        logic [31:0]   j;
        logic [31:0]   phase;
        logic [31:0]   fs;
        logic [31:0]   fb;
        logic [31:0]   half;
        longint        cx;
        longint        cy;
        longint        cz;
        longint        ang;
        longint        cs;
        longint        sn;
        longint        dx;
        longint        dy;
        longint        x;
        longint        y;
        longint        zb;
        longint        zt;
        int            start;
        mesh_result_t  r;
        n = (seg_count > 11'd1024) ? 32'd1024 : {21'd0, seg_count};
        i = {22'd0, seg};
        start = pending_results.size();
        if (i >= n)
        begin
            r = '{ctess_pkg::KindStrokeVtx, 14'd0, 32'd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1};
            pending_results.push_back(r);
            return;
        end
        j = (i + 1) % n;
        phase = 32'((64'(i) << 32) / 64'(n));
        // CORDIC rotation within the quadrant, then map to the full circle.
        ang = longint'({34'd0, phase[29:0]});
        cs = 64'sd652032874;
        sn = 0;
        for (int k = 0; k < 30; k++)
        begin
            dx = sn >>> k;
            dy = cs >>> k;
            if (ang >= 0)
            begin
                cs = cs - dx;
                sn = sn + dy;
                ang = ang - longint'({34'd0, ctess_pkg::AtanTurns[k]});
            end
            else
            begin
                cs = cs + dx;
                sn = sn - dy;
                ang = ang + longint'({34'd0, ctess_pkg::AtanTurns[k]});
            end
        end
        case (phase[31:30])
            2'd0: begin x = cs;  y = sn;  end
            2'd1: begin x = -sn; y = cs;  end
            2'd2: begin x = -cs; y = -sn; end
            default: begin x = sn; y = -cs; end
        endcase
        x = rim_position(x, cen_x);
        y = rim_position(y, cen_y);
        cx = longint'(signed'(cen_x));
        cy = longint'(signed'(cen_y));
        cz = longint'(signed'(cen_z));
        half = hgt >> 1;
        zb = clamp32(cz - longint'({32'd0, half}));
        zt = clamp32(cz + longint'({32'd0, half}));
        fs = mode[1] ? 2 * n : 32'd0;
        fb = vbase + fs;
        if (mode[0])
        begin
            add_result(ctess_pkg::KindFillVtx, fs + i + 1, 0, x, y, zb);
            add_result(ctess_pkg::KindFillVtx, fs + n + 2 + i, 0, x, y, zt);
            if (i == 0)
            begin
                add_result(ctess_pkg::KindFillVtx, fs, 0, cx, cy, zb);
                add_result(ctess_pkg::KindFillVtx, fs + n + 1, 0, cx, cy, zt);
            end
            add_result(ctess_pkg::KindFillIdx, 3 * i, fb, 0, 0, 0);
            add_result(ctess_pkg::KindFillIdx, 3 * i + 1, fb + 1 + j, 0, 0, 0);
            add_result(ctess_pkg::KindFillIdx, 3 * i + 2, fb + 1 + i, 0, 0, 0);
            add_result(ctess_pkg::KindFillIdx, 3 * n + 3 * i, fb + n + 1, 0, 0, 0);
            add_result(ctess_pkg::KindFillIdx, 3 * n + 3 * i + 1, fb + n + 2 + i, 0, 0, 0);
            add_result(ctess_pkg::KindFillIdx, 3 * n + 3 * i + 2, fb + n + 2 + j, 0, 0, 0);
            add_result(ctess_pkg::KindFillIdx, 6 * n + 6 * i, fb + i + 1, 0, 0, 0);
            add_result(ctess_pkg::KindFillIdx, 6 * n + 6 * i + 1, fb + j + 1, 0, 0, 0);
            add_result(ctess_pkg::KindFillIdx, 6 * n + 6 * i + 2, fb + n + 2 + j, 0, 0, 0);
            add_result(ctess_pkg::KindFillIdx, 6 * n + 6 * i + 3, fb + i + 1, 0, 0, 0);
            add_result(ctess_pkg::KindFillIdx, 6 * n + 6 * i + 4, fb + n + 2 + j, 0, 0, 0);
            add_result(ctess_pkg::KindFillIdx, 6 * n + 6 * i + 5, fb + n + 2 + i, 0, 0, 0);
        end
        if (mode[1])
        begin
            add_result(ctess_pkg::KindStrokeVtx, i, 0, x, y, zb);
            add_result(ctess_pkg::KindStrokeVtx, n + i, 0, x, y, zt);
            add_result(ctess_pkg::KindStrokeIdx, 2 * i, vbase + i, 0, 0, 0);
            add_result(ctess_pkg::KindStrokeIdx, 2 * i + 1, vbase + j, 0, 0, 0);
            add_result(ctess_pkg::KindStrokeIdx, 2 * n + 2 * i, vbase + n + i, 0, 0, 0);
            add_result(ctess_pkg::KindStrokeIdx, 2 * n + 2 * i + 1, vbase + n + j, 0, 0, 0);
            add_result(ctess_pkg::KindStrokeIdx, 4 * n + 2 * i, vbase + i, 0, 0, 0);
            add_result(ctess_pkg::KindStrokeIdx, 4 * n + 2 * i + 1, vbase + i + n, 0, 0, 0);
        end
        if (pending_results.size() > start)
            pending_results[pending_results.size() - 1].last = 1'b1;
    endfunction

    // Sends one segment request and records its expected results on acceptance.
    task automatic send_segment(input logic [9:0] seg);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        segment  <= seg;
        do
            @(posedge clk);
        while (!in_ready);
        tessellate_segment(seg);
    endtask

    // Waits until every expected result has arrived and the pipeline is empty.
    task automatic drain_all();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Writes one register through the configuration port and the shadow copy.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ctess_pkg::RegSegments:   seg_count = value[10:0];
            ctess_pkg::RegRadius:     rad       = value;
            ctess_pkg::RegHeight:     hgt       = value;
            ctess_pkg::RegCenterX:    cen_x     = value;
            ctess_pkg::RegCenterY:    cen_y     = value;
            ctess_pkg::RegCenterZ:    cen_z     = value;
            ctess_pkg::RegDrawMode:   mode      = value[1:0];
            ctess_pkg::RegVertexBase: vbase     = value;
            default: ;
        endcase
    endtask

    task automatic set_shape(input logic [10:0] n, input logic [31:0] r, input logic [31:0] h,
                             input logic [1:0] m, input logic [31:0] vb);
        drain_all();
        write_reg(ctess_pkg::RegSegments, {21'd0, n});
        write_reg(ctess_pkg::RegRadius, r);
        write_reg(ctess_pkg::RegHeight, h);
        write_reg(ctess_pkg::RegDrawMode, {30'd0, m});
        write_reg(ctess_pkg::RegVertexBase, vb);
    endtask

    task automatic set_centre(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        drain_all();
        write_reg(ctess_pkg::RegCenterX, x);
        write_reg(ctess_pkg::RegCenterY, y);
        write_reg(ctess_pkg::RegCenterZ, z);
    endtask

    // Reset values: first, wrapping and out-of-range segments.
    task automatic test_reset_values();
        send_segment(10'd0);
        send_segment(10'd1);
        send_segment(10'd59);
        send_segment(10'd60);
        send_segment(10'd1023);
    endtask

    // Draw modes 3, 2 and 0, including the one that produces nothing.
    task automatic test_draw_modes();
        set_shape(11'd7, 32'h0003_8000, 32'h0002_0001, 2'd3, 32'h0000_0010);
        send_segment(10'd0);
        send_segment(10'd6);
        set_shape(11'd7, 32'h0003_8000, 32'h0002_0001, 2'd2, 32'h0000_0010);
        send_segment(10'd3);
        send_segment(10'd0);
        set_shape(11'd7, 32'h0003_8000, 32'h0002_0001, 2'd0, 32'h0000_0010);
        send_segment(10'd2);
        send_segment(10'd7);
        send_segment(10'd4);
    endtask

    // Field extremes: saturation, index wrap, smallest and largest counts.
    task automatic test_extremes();
        set_centre(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        set_shape(11'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFE);
        send_segment(10'd0);
        send_segment(10'd1);
        send_segment(10'd2);
        send_segment(10'd3);
        set_centre(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        set_shape(11'd1024, 32'h0000_0000, 32'h0000_0000, 2'd3, 32'h0000_0000);
        send_segment(10'd1023);
        send_segment(10'd512);
        set_centre(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        set_shape(11'd2047, 32'h0010_0000, 32'h0001_0000, 2'd1, 32'h0000_0100);
        send_segment(10'd1023);
        send_segment(10'd255);
        set_shape(11'd0, 32'h0010_0000, 32'h0001_0000, 2'd3, 32'h0000_0100);
        send_segment(10'd0);
    endtask

    // Random configuration phases, each with a burst of random segments.
    task automatic test_random_phases();
        logic [10:0] n;
        int          eff;
        int          count;
        for (int p = 0; p < 9; p++)
        begin
            if (p == 4)
                n = 11'd1024;
            else if ($urandom_range(0, 7) == 0)
                n = 11'($urandom_range(0, 2047));
            else
                n = 11'($urandom_range(3, 64));
            set_centre($urandom, $urandom, $urandom);
            set_shape(n, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h00FF_FFFF),
                      $urandom, 2'($urandom_range(1, 3)), $urandom);
            eff = (n > 11'd1024) ? 1024 : int'(n);
            steady_flow = (p % 3 == 2);
            count = 23;
            for (int k = 0; k < count; k++)
            begin
                if (eff > 0 && $urandom_range(0, 9) < 8)
                    send_segment(10'($urandom_range(0, eff - 1)));
                else
                    send_segment(10'($urandom_range(0, 1023)));
            end
            steady_flow = 1'b0;
        end
    endtask

    // Result acceptance and field comparison against the oldest expectation.
    always @(posedge clk)
    begin
        mesh_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: kind %0d slot %0d", kind, slot);
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (kind !== e.kind)
                begin
                    $error("kind: expected %0d, got %0d", e.kind, kind);
                    fail_count++;
                end
                if (slot !== e.slot)
                begin
                    $error("slot: expected %0d, got %0d", e.slot, slot);
                    fail_count++;
                end
                if (index_value !== e.index_value)
                begin
                    $error("index_value: expected %0d, got %0d", e.index_value, index_value);
                    fail_count++;
                end
                if (pos_x !== e.pos_x)
                begin
                    $error("pos_x: expected %0d, got %0d", e.pos_x, pos_x);
                    fail_count++;
                end
                if (pos_y !== e.pos_y)
                begin
                    $error("pos_y: expected %0d, got %0d", e.pos_y, pos_y);
                    fail_count++;
                end
                if (pos_z !== e.pos_z)
                begin
                    $error("pos_z: expected %0d, got %0d", e.pos_z, pos_z);
                    fail_count++;
                end
                if (bad_segment !== e.bad_segment)
                begin
                    $error("bad_segment: expected %0d, got %0d", e.bad_segment, bad_segment);
                    fail_count++;
                end
                if (last !== e.last)
                begin
                    $error("last: expected %0d, got %0d", e.last, last);
                    fail_count++;
                end
            end
        end
    end

    // Receiver back-pressure with short and occasional long stalls.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (steady_flow || $urandom_range(0, 9) < 7)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            stall_left <= pick_gap();
            out_ready  <= 1'b0;
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        segment     = '0;
        out_ready   = 1'b0;
        fail_count  = 0;
        cycle_count = 0;
        stall_left  = 0;
        steady_flow = 1'b0;
        seg_count   = 11'd60;
        rad         = 32'd65536;
        hgt         = 32'd65536;
        cen_x       = 32'd0;
        cen_y       = 32'd0;
        cen_z       = 32'd0;
        mode        = 2'd1;
        vbase       = 32'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_values();
        test_draw_modes();
        test_extremes();
        test_random_phases();
        drain_all();

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
